@@ hw/rtl/bpms_pkg.sv @@
// Types, constants and mode codes shared by the power mode sequencer files.
package bpms_pkg;

  // Cell voltage width in bits (millivolts)
  localparam int unsigned VoltBits = 16;

  // Button press event code from the encoder
  localparam logic EncoderEventButtonPress = 1'b1;

  // Operating modes
  typedef enum logic [3:0] {
    OP_DUAL      = 4'd0,
    OP_RECEIVE   = 4'd1,
    OP_SUPPLY    = 4'd2,
    OP_MONITOR   = 4'd3,
    OP_BALANCE   = 4'd4,
    OP_SELECT    = 4'd5,
    OP_CHG_FAULT = 4'd6,
    OP_OVERTEMP  = 4'd7,
    OP_UNDERVOLT = 4'd8
  } mode_e;

  localparam mode_e ModeLast = OP_UNDERVOLT;

  // One control tick
  typedef struct packed {
    logic                charge_temp_ok;
    logic                discharge_temp_ok;
    logic                balance_needed;
    logic                charge_current_ok;
    logic                fully_charged;
    logic                depleted;
    logic                button_press;
    logic [3:0]          menu_choice;
    logic [VoltBits-1:0] upper_cell_mv;
    logic [VoltBits-1:0] lower_cell_mv;
  } tick_t;

  // One result
  typedef struct packed {
    mode_e mode;
    logic  charge_enable;
    logic  supply_enable;
    logic  upper_bleed;
    logic  lower_bleed;
    logic  duty_refresh;
  } result_t;

  // Bleed switch state carried from tick to tick
  typedef struct packed {
    logic upper;
    logic lower;
  } bleed_t;

endpackage

@@ hw/rtl/bpms_if.sv @@
// Valid/ready channel interfaces for ticks and results.
interface bpms_tick_if;
  logic                          valid;
  logic                          ready;
  logic                          charge_temp_ok;
  logic                          discharge_temp_ok;
  logic                          balance_needed;
  logic                          charge_current_ok;
  logic                          fully_charged;
  logic                          depleted;
  logic                          button_press;
  logic [3:0]                    menu_choice;
  logic [bpms_pkg::VoltBits-1:0] upper_cell_mv;
  logic [bpms_pkg::VoltBits-1:0] lower_cell_mv;

  modport source (
    output valid, charge_temp_ok, discharge_temp_ok, balance_needed, charge_current_ok,
           fully_charged, depleted, button_press, menu_choice, upper_cell_mv, lower_cell_mv,
    input  ready
  );
  modport sink (
    input  valid, charge_temp_ok, discharge_temp_ok, balance_needed, charge_current_ok,
           fully_charged, depleted, button_press, menu_choice, upper_cell_mv, lower_cell_mv,
    output ready
  );
endinterface

interface bpms_result_if;
  logic                  valid;
  logic                  ready;
  logic [3:0]            mode;
  logic                  charge_enable;
  logic                  supply_enable;
  logic                  upper_bleed;
  logic                  lower_bleed;
  logic                  duty_refresh;

  modport source (
    output valid, mode, charge_enable, supply_enable, upper_bleed, lower_bleed, duty_refresh,
    input  ready
  );
  modport sink (
    input  valid, mode, charge_enable, supply_enable, upper_bleed, lower_bleed, duty_refresh,
    output ready
  );
endinterface

@@ hw/rtl/bpms_mode_logic.sv @@
// Next-mode priority chains and output decode for one control tick.
module bpms_mode_logic (
  input  bpms_pkg::mode_e   cur_mode_i,
  input  bpms_pkg::bleed_t  bleed_held_i,
  input  bpms_pkg::tick_t   tick_i,
  output bpms_pkg::mode_e   mode_nxt_o,
  output bpms_pkg::result_t result_o
);
  import bpms_pkg::*;

  logic press;
  logic choice_ok;

  assign press     = (tick_i.button_press == EncoderEventButtonPress);
  assign choice_ok = (tick_i.menu_choice <= 4'(ModeLast));

  // Per-mode priority chains, first match wins
  always_comb begin
    mode_nxt_o = cur_mode_i;
    case (cur_mode_i)
      OP_DUAL: begin
        if (!tick_i.charge_temp_ok)         mode_nxt_o = OP_OVERTEMP;
        else if (!tick_i.charge_current_ok) mode_nxt_o = OP_CHG_FAULT;
        else if (tick_i.fully_charged)      mode_nxt_o = OP_MONITOR;
        else if (!tick_i.discharge_temp_ok) mode_nxt_o = OP_OVERTEMP;
        else if (tick_i.depleted)           mode_nxt_o = OP_UNDERVOLT;
        else if (tick_i.balance_needed)     mode_nxt_o = OP_BALANCE;
        else if (press)                     mode_nxt_o = OP_SELECT;
      end
      OP_RECEIVE: begin
        if (!tick_i.charge_temp_ok)         mode_nxt_o = OP_OVERTEMP;
        else if (tick_i.balance_needed)     mode_nxt_o = OP_BALANCE;
        else if (!tick_i.charge_current_ok) mode_nxt_o = OP_CHG_FAULT;
        else if (tick_i.fully_charged)      mode_nxt_o = OP_MONITOR;
        else if (press)                     mode_nxt_o = OP_SELECT;
      end
      OP_SUPPLY: begin
        if (!tick_i.discharge_temp_ok)      mode_nxt_o = OP_OVERTEMP;
        else if (tick_i.depleted)           mode_nxt_o = OP_UNDERVOLT;
        else if (tick_i.balance_needed)     mode_nxt_o = OP_BALANCE;
        else if (press)                     mode_nxt_o = OP_SELECT;
      end
      OP_MONITOR: begin
        if (tick_i.balance_needed)          mode_nxt_o = OP_BALANCE;
        else if (press)                     mode_nxt_o = OP_SELECT;
      end
      OP_BALANCE: begin
        if (!tick_i.discharge_temp_ok)      mode_nxt_o = OP_OVERTEMP;
        else if (tick_i.depleted)           mode_nxt_o = OP_UNDERVOLT;
        else if (!tick_i.balance_needed)    mode_nxt_o = OP_MONITOR;
      end
      OP_SELECT: begin
        // out-of-range choice is ignored
        if (press && choice_ok)             mode_nxt_o = mode_e'(tick_i.menu_choice);
      end
      OP_CHG_FAULT, OP_OVERTEMP, OP_UNDERVOLT: begin
        if (press)                          mode_nxt_o = OP_SELECT;
      end
      default: mode_nxt_o = OP_MONITOR;
    endcase
  end

  // Output decode from the new mode
  always_comb begin
    result_o               = '0;
    result_o.mode          = mode_nxt_o;
    case (mode_nxt_o)
      OP_DUAL: begin
        result_o.charge_enable = 1'b1;
        result_o.supply_enable = 1'b1;
        result_o.duty_refresh  = 1'b1;
      end
      OP_RECEIVE: begin
        result_o.charge_enable = 1'b1;
        result_o.duty_refresh  = 1'b1;
      end
      OP_SUPPLY: begin
        // bleed switches keep last tick's setting
        result_o.supply_enable = 1'b1;
        result_o.upper_bleed   = bleed_held_i.upper;
        result_o.lower_bleed   = bleed_held_i.lower;
      end
      OP_BALANCE: begin
        // bleed the higher cell; on a tie the lower one
        if (tick_i.upper_cell_mv > tick_i.lower_cell_mv) begin
          result_o.upper_bleed = 1'b1;
        end else begin
          result_o.lower_bleed = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/battery_power_mode_sequencer_unit.sv @@
// Battery power mode sequencer: top level with tick and result registers.
//
//  channel | dir | contents
//  --------+-----+---------------------------------------------------------
//  in_i    | in  | status flags, button press, menu choice, two cell voltages
//  out_o   | out | mode, charge/supply enables, bleed switches, duty refresh
//
// One tick accepted per cycle while out_o is not stalled; its result passes through the
// tick register, then the result register, before it is valid on out_o.
// Mode and held bleed bits update when a tick moves into the result register.
// A stall on out_o holds the result; one more tick parks in the tick register.
// Reset starts in dual mode with both bleed switches off.
module battery_power_mode_sequencer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpms_tick_if.sink     in_i,
  bpms_result_if.source out_o
);
  import bpms_pkg::*;

  logic    tick_valid_q;
  tick_t   tick_q;
  logic    out_valid_q;
  result_t out_q;
  mode_e   mode_q, mode_d;
  bleed_t  bleed_q;
  result_t result_d;
  logic    advance;
  logic    in_xfer;

  // Pipeline handshake
  assign advance  = tick_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !tick_valid_q || advance;
  assign in_xfer  = in_i.valid && in_i.ready;

  // Tick register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_valid_q <= 1'b0;
    end else if (in_xfer) begin
      tick_valid_q <= 1'b1;
    end else if (advance) begin
      tick_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tick_q.charge_temp_ok    <= in_i.charge_temp_ok;
      tick_q.discharge_temp_ok <= in_i.discharge_temp_ok;
      tick_q.balance_needed    <= in_i.balance_needed;
      tick_q.charge_current_ok <= in_i.charge_current_ok;
      tick_q.fully_charged     <= in_i.fully_charged;
      tick_q.depleted          <= in_i.depleted;
      tick_q.button_press      <= in_i.button_press;
      tick_q.menu_choice       <= in_i.menu_choice;
      tick_q.upper_cell_mv     <= in_i.upper_cell_mv;
      tick_q.lower_cell_mv     <= in_i.lower_cell_mv;
    end
  end

  // Mode transition and output decode
  bpms_mode_logic u_mode_logic (
    .cur_mode_i   (mode_q),
    .bleed_held_i (bleed_q),
    .tick_i       (tick_q),
    .mode_nxt_o   (mode_d),
    .result_o     (result_d)
  );

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= OP_DUAL;
      bleed_q <= '0;
    end else if (advance) begin
      mode_q        <= mode_d;
      bleed_q.upper <= result_d.upper_bleed;
      bleed_q.lower <= result_d.lower_bleed;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.mode          = out_q.mode;
  assign out_o.charge_enable = out_q.charge_enable;
  assign out_o.supply_enable = out_q.supply_enable;
  assign out_o.upper_bleed   = out_q.upper_bleed;
  assign out_o.lower_bleed   = out_q.lower_bleed;
  assign out_o.duty_refresh  = out_q.duty_refresh;

endmodule

@@ hw/rtl/bpms_checker.sv @@
// Port-level checks on the sequencer's result channel, bound to the top level.
module bpms_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] mode_i,
  input logic       charge_enable_i,
  input logic       supply_enable_i,
  input logic       upper_bleed_i,
  input logic       lower_bleed_i,
  input logic       duty_refresh_i
);
  import bpms_pkg::*;

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mode_i)
      && $stable(upper_bleed_i) && $stable(lower_bleed_i))
    else $error("result changed while stalled");

  // Never bleed both cells at once
  a_one_bleed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(upper_bleed_i && lower_bleed_i))
    else $error("both bleed switches on");

  // Balancing always bleeds exactly one cell
  a_bal_bleed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mode_i == 4'(OP_BALANCE) |-> upper_bleed_i != lower_bleed_i)
    else $error("balancing without a bleed switch");

  // Charge path and duty refresh only in dual or receiving
  a_charge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (charge_enable_i || duty_refresh_i) |->
      charge_enable_i == duty_refresh_i
      && (mode_i == 4'(OP_DUAL) || mode_i == 4'(OP_RECEIVE)))
    else $error("charge enable outside a charging mode");

  // Supply path only in dual or supplying
  a_supply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && supply_enable_i |->
      mode_i == 4'(OP_DUAL) || mode_i == 4'(OP_SUPPLY))
    else $error("supply enable outside a supplying mode");

endmodule

bind battery_power_mode_sequencer_unit bpms_checker u_bpms_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .mode_i          (out_o.mode),
  .charge_enable_i (out_o.charge_enable),
  .supply_enable_i (out_o.supply_enable),
  .upper_bleed_i   (out_o.upper_bleed),
  .lower_bleed_i   (out_o.lower_bleed),
  .duty_refresh_i  (out_o.duty_refresh)
);

@@ tb/testbench.sv @@
// Testbench for the power mode sequencer: directed ticks, then random ticks, checked by a predictor.
`timescale 1ns / 100ps

module testbench;
  import bpms_pkg::*;

  // One row of stimulus; a typed-in result overrides the predictor for that row
  typedef struct {
    tick_t   t;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  bpms_tick_if   tick_ch ();
  bpms_result_if res_ch ();

  battery_power_mode_sequencer_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tick_ch),
    .out_o  (res_ch)
  );

  stim_row_t   stim_rows[$];
  result_t     due_results[$];
  int unsigned snd_idx = 0;
  int unsigned snd_gap = 0;
  int unsigned rcv_gap = 0;
  int unsigned fault_count = 0;
  bit          hold_off = 1'b0;
  bit          calm = 1'b0;

  // Sequencer state as the predictor sees it
  mode_e  tracked_mode;
  bleed_t tracked_bleed;

  // Mode move for one tick, per-mode priority chains
  function automatic mode_e mode_after(mode_e m, tick_t t);
    logic press;
    press = (t.button_press == EncoderEventButtonPress);
    case (m)
      OP_DUAL: begin
        if (!t.charge_temp_ok) return OP_OVERTEMP;
        if (!t.charge_current_ok) return OP_CHG_FAULT;
        if (t.fully_charged) return OP_MONITOR;
        if (!t.discharge_temp_ok) return OP_OVERTEMP;
        if (t.depleted) return OP_UNDERVOLT;
        if (t.balance_needed) return OP_BALANCE;
        if (press) return OP_SELECT;
        return m;
      end
      OP_RECEIVE: begin
        if (!t.charge_temp_ok) return OP_OVERTEMP;
        if (t.balance_needed) return OP_BALANCE;
        if (!t.charge_current_ok) return OP_CHG_FAULT;
        if (t.fully_charged) return OP_MONITOR;
        if (press) return OP_SELECT;
        return m;
      end
      OP_SUPPLY: begin
        if (!t.discharge_temp_ok) return OP_OVERTEMP;
        if (t.depleted) return OP_UNDERVOLT;
        if (t.balance_needed) return OP_BALANCE;
        if (press) return OP_SELECT;
        return m;
      end
      OP_MONITOR: begin
        if (t.balance_needed) return OP_BALANCE;
        if (press) return OP_SELECT;
        return m;
      end
      OP_BALANCE: begin
        if (!t.discharge_temp_ok) return OP_OVERTEMP;
        if (t.depleted) return OP_UNDERVOLT;
        if (!t.balance_needed) return OP_MONITOR;
        return m;
      end
      OP_SELECT: begin
        // out-of-range choice is ignored
        if (press && t.menu_choice <= 4'(ModeLast)) return mode_e'(t.menu_choice);
        return m;
      end
      OP_CHG_FAULT, OP_OVERTEMP, OP_UNDERVOLT: begin
        if (press) return OP_SELECT;
        return m;
      end
      default: return OP_MONITOR;
    endcase
  endfunction

  // Advance the tracked state by one tick and return the outputs it drives
  function automatic result_t step_sequencer(tick_t t);
    result_t r;
    mode_e   m;
    m = mode_after(tracked_mode, t);
    r = '0;
    r.mode = m;
    case (m)
      OP_DUAL: begin
        r.charge_enable = 1'b1;
        r.supply_enable = 1'b1;
        r.duty_refresh  = 1'b1;
      end
      OP_RECEIVE: begin
        r.charge_enable = 1'b1;
        r.duty_refresh  = 1'b1;
      end
      OP_SUPPLY: begin
        // bleed switches repeat last tick's values
        r.supply_enable = 1'b1;
        r.upper_bleed   = tracked_bleed.upper;
        r.lower_bleed   = tracked_bleed.lower;
      end
      OP_BALANCE: begin
        // bleed the higher cell, lower one on a tie
        if (t.upper_cell_mv > t.lower_cell_mv) r.upper_bleed = 1'b1;
        else r.lower_bleed = 1'b1;
      end
      default: ;
    endcase
    tracked_mode        = m;
    tracked_bleed.upper = r.upper_bleed;
    tracked_bleed.lower = r.lower_bleed;
    return r;
  endfunction

  function automatic tick_t tk(logic ct, logic dt, logic bal, logic cur, logic full,
                               logic dep, logic press, logic [3:0] choice,
                               logic [VoltBits-1:0] up, logic [VoltBits-1:0] lo);
    tick_t t;
    t.charge_temp_ok    = ct;
    t.discharge_temp_ok = dt;
    t.balance_needed    = bal;
    t.charge_current_ok = cur;
    t.fully_charged     = full;
    t.depleted          = dep;
    t.button_press      = press;
    t.menu_choice       = choice;
    t.upper_cell_mv     = up;
    t.lower_cell_mv     = lo;
    return t;
  endfunction

  function automatic result_t rs(mode_e m, logic chg, logic sup, logic ub, logic lb,
                                 logic duty);
    result_t r;
    r.mode          = m;
    r.charge_enable = chg;
    r.supply_enable = sup;
    r.upper_bleed   = ub;
    r.lower_bleed   = lb;
    r.duty_refresh  = duty;
    return r;
  endfunction

  task automatic add_row(tick_t t, bit typed = 1'b0, result_t want = '0);
    stim_row_t row;
    row.t     = t;
    row.typed = typed;
    row.want  = want;
    stim_rows.push_back(row);
  endtask

  // Random tick: mostly healthy flags so the menu opens every mode, some raw noise
  function automatic tick_t rand_tick();
    tick_t       t;
    logic [63:0] raw;
    if ($urandom_range(0, 99) < 10) begin
      raw = {$urandom, $urandom};
      t = raw[$bits(tick_t)-1:0];
      return t;
    end
    t.charge_temp_ok    = $urandom_range(0, 99) < 90;
    t.discharge_temp_ok = $urandom_range(0, 99) < 90;
    t.charge_current_ok = $urandom_range(0, 99) < 90;
    t.fully_charged     = $urandom_range(0, 99) < 8;
    t.depleted          = $urandom_range(0, 99) < 8;
    t.balance_needed    = $urandom_range(0, 99) < 25;
    t.button_press      = $urandom_range(0, 99) < 35;
    t.menu_choice = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
    case ($urandom_range(0, 4))
      0: begin
        t.upper_cell_mv = VoltBits'($urandom);
        t.lower_cell_mv = VoltBits'($urandom);
      end
      1: begin
        t.upper_cell_mv = VoltBits'($urandom);
        t.lower_cell_mv = t.upper_cell_mv;
      end
      2: begin
        t.lower_cell_mv = VoltBits'($urandom);
        t.upper_cell_mv = t.lower_cell_mv + 1'b1;
        if ($urandom_range(0, 1)) {t.upper_cell_mv, t.lower_cell_mv} =
            {t.lower_cell_mv, t.upper_cell_mv};
      end
      3: begin
        t.upper_cell_mv = $urandom_range(0, 1) ? '1 : '0;
        t.lower_cell_mv = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
        // typical cell levels within 100 mV of each other
        t.upper_cell_mv = VoltBits'($urandom_range(3650, 3750));
        t.lower_cell_mv = VoltBits'($urandom_range(3650, 3750));
      end
    endcase
    return t;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic drive_tick(tick_t t);
    tick_ch.charge_temp_ok    <= t.charge_temp_ok;
    tick_ch.discharge_temp_ok <= t.discharge_temp_ok;
    tick_ch.balance_needed    <= t.balance_needed;
    tick_ch.charge_current_ok <= t.charge_current_ok;
    tick_ch.fully_charged     <= t.fully_charged;
    tick_ch.depleted          <= t.depleted;
    tick_ch.button_press      <= t.button_press;
    tick_ch.menu_choice       <= t.menu_choice;
    tick_ch.upper_cell_mv     <= t.upper_cell_mv;
    tick_ch.lower_cell_mv     <= t.lower_cell_mv;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Quiet stretches: no idling on either side while calm is set
  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  // Long receiver hold-off, twice, so the block fills and stalls its input
  initial begin
    @(posedge rst_n);
    for (int k = 0; k < 2; k++) begin
      while (snd_idx < (k == 0 ? 300 : 1200)) @(posedge clk);
      hold_off <= 1'b1;
      repeat (40) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // Tick sender; predicts each transfer as it is accepted
  always @(posedge clk or negedge rst_n) begin : sender
    result_t r;
    if (!rst_n) begin
      tick_ch.valid <= 1'b0;
      drive_tick('0);
      snd_gap = 0;
    end else begin
      if (tick_ch.valid && tick_ch.ready) begin
        r = step_sequencer(stim_rows[snd_idx].t);
        due_results.push_back(stim_rows[snd_idx].typed ? stim_rows[snd_idx].want : r);
        snd_idx++;
      end
      if (!tick_ch.valid || tick_ch.ready) begin
        if (snd_gap > 0) begin
          tick_ch.valid <= 1'b0;
          snd_gap--;
        end else if (snd_idx < stim_rows.size()) begin
          tick_ch.valid <= 1'b1;
          drive_tick(stim_rows[snd_idx].t);
          snd_gap = (calm || hold_off) ? 0 : pick_gap();
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver and checker
  always @(posedge clk or negedge rst_n) begin : receiver
    result_t want;
    logic [$bits(result_t)-1:0] got;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      rcv_gap = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.mode, res_ch.charge_enable, res_ch.supply_enable,
               res_ch.upper_bleed, res_ch.lower_bleed, res_ch.duty_refresh};
        if (due_results.size() == 0) begin
          if (fault_count < 10) $display("unexpected result %h with nothing due", got);
          fault_count++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            if (fault_count < 10)
              $display("mismatch: mode %0d/%0d chg %b/%b sup %b/%b ub %b/%b lb %b/%b duty %b/%b",
                       want.mode, res_ch.mode, want.charge_enable, res_ch.charge_enable,
                       want.supply_enable, res_ch.supply_enable, want.upper_bleed,
                       res_ch.upper_bleed, want.lower_bleed, res_ch.lower_bleed,
                       want.duty_refresh, res_ch.duty_refresh);
            fault_count++;
          end
        end
      end
      if (hold_off) begin
        res_ch.ready <= 1'b0;
      end else if (rcv_gap > 0) begin
        res_ch.ready <= 1'b0;
        rcv_gap--;
      end else begin
        res_ch.ready <= 1'b1;
        if (!calm) rcv_gap = pick_gap();
      end
    end
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Stimulus table, reset and end of run
  initial begin
    rst_n = 1'b0;
    tick_ch.valid = 1'b0;
    res_ch.ready = 1'b0;
    tick_ch.charge_temp_ok = 1'b0;
    tick_ch.discharge_temp_ok = 1'b0;
    tick_ch.balance_needed = 1'b0;
    tick_ch.charge_current_ok = 1'b0;
    tick_ch.fully_charged = 1'b0;
    tick_ch.depleted = 1'b0;
    tick_ch.button_press = 1'b0;
    tick_ch.menu_choice = '0;
    tick_ch.upper_cell_mv = '0;
    tick_ch.lower_cell_mv = '0;
    tracked_mode = OP_DUAL;
    tracked_bleed = '0;

    // directed walk through every mode and the corner cases
    add_row(tk(1, 1, 0, 1, 0, 0, 0, 0, 0, 0), 1, rs(OP_DUAL, 1, 1, 0, 0, 1));
    add_row(tk(1, 1, 0, 1, 0, 0, 1, 0, 0, 0), 1, rs(OP_SELECT, 0, 0, 0, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 1, OP_SUPPLY, 0, 0), 1,
            rs(OP_SUPPLY, 0, 1, 0, 0, 0));
    add_row(tk(1, 1, 1, 1, 0, 0, 0, 0, '1, 0), 1, rs(OP_BALANCE, 0, 0, 1, 0, 0));
    // tie at full scale bleeds the lower cell
    add_row(tk(1, 1, 1, 1, 0, 0, 0, 0, '1, '1), 1, rs(OP_BALANCE, 0, 0, 0, 1, 0));
    add_row(tk(1, 1, 1, 1, 0, 0, 0, 0, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 0, 0, 0, 0));
    add_row(tk(0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    // choice above the last mode is ignored
    add_row(tk(1, 1, 0, 1, 0, 0, 1, 4'd9, 0, 0), 1, rs(OP_SELECT, 0, 0, 0, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 1, 4'd15, 0, 0), 1, rs(OP_SELECT, 0, 0, 0, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 0, OP_RECEIVE, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 1, OP_RECEIVE, 0, 0), 1,
            rs(OP_RECEIVE, 1, 0, 0, 0, 1));
    add_row(tk(0, 1, 0, 1, 0, 0, 0, 0, 0, 0), 1, rs(OP_OVERTEMP, 0, 0, 0, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 1, 0, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 1, OP_DUAL, 0, 0), 1, rs(OP_DUAL, 1, 1, 0, 0, 1));
    add_row(tk(1, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1, rs(OP_CHG_FAULT, 0, 0, 0, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 1, 0, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 1, OP_UNDERVOLT, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 1, 0, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 1, OP_SELECT, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 1, OP_DUAL, 0, 0));
    add_row(tk(1, 1, 0, 1, 1, 0, 0, 0, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 1, 0, 0, 0));
    add_row(tk(1, 1, 0, 1, 0, 0, 1, OP_BALANCE, 0, '1));
    add_row(tk(1, 1, 1, 1, 0, 1, 0, 0, '1, 0));

    // random ticks
    repeat (1800) add_row(rand_tick());

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // drain: everything sent, everything received, then end the run
    while (snd_idx < stim_rows.size() || due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fault_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
